>>> rtl/particle_spring_force_defines.svh
// Assertion macros shared by the spring force RTL.
`ifndef PARTICLE_SPRING_FORCE_DEFINES_SVH
`define PARTICLE_SPRING_FORCE_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset
`define PSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spring force assertion failed");

// Next-cycle implication, checked on clk outside reset
`define PSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spring force assertion failed");

`endif

>>> rtl/psf_pkg.sv
// Shared constants and types of the spring force pipeline.
`timescale 1ns / 1ps
`default_nettype none
package psf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PW   = 32;           // position and force width
  localparam int DW   = PW + 1;       // difference width
  localparam int SQW  = 2 * DW;       // sum of squares width
  localparam int LW   = DW;           // length width
  localparam int RMW  = LW + 3;       // root remainder width
  localparam int SCW  = LW + PW;      // k * stretch width
  localparam int NW   = SCW + DW;     // numerator width
  localparam int NSW  = NW - FRAC_BITS;
  localparam int QW   = PW - 1;       // unsaturated quotient bits
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_SPRING = 2'd0;
  localparam logic [CFG_IW-1:0] REG_REST   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BUNGEE = 2'd2;

  typedef struct packed {
    logic [PW-1:0]   k;
    logic [PW-2:0]   rest;
    logic            bungee;
  } cfg_t;

  typedef struct packed {
    logic [2:0][DW-1:0] dmag;
    logic [2:0]         dneg;
  } dvec_t;

  typedef struct packed {
    logic       kill;
    logic [2:0] sat;
    logic [2:0] dneg;
    logic [2:0] dnz;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [LW-1:0]       len;
    logic [2:0][NSW-1:0] num;
  } div_in_t;

endpackage
`default_nettype wire

>>> rtl/particle_spring_force.sv
// Hooke spring force between a particle and the spring's other end.
//
// Input channel in_valid/in_ready carries one request: particle and other-end
// positions, signed Q16.16. Output channel out_valid/out_ready returns one
// force request per input, in order: three saturated Q16.16 components and
// force_applied (low for zero length or bungee slack, forces then zero).
// The cfg_ channel writes spring_constant (0), rest_length (1) and
// bungee_mode (2); cfg_ready is always high, other indexes are ignored.
// Write configuration only while no request is in flight.
// Throughput is one request per cycle unless the receiver stalls. The path passes
// through 3 stages of differences and squares, 33 square-root stages
// (one root bit each), 7 stages of products and saturation test, 31 divider
// stages (one quotient bit each) and the output register.
// The pipeline advances as a whole; when the receiver stalls it keeps moving
// until a result reaches the stage in front of the held output register,
// then in_ready drops until the output is taken.
// Synchronous reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_spring_force_defines.svh"
module particle_spring_force (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [psf_pkg::PW-1:0] in_particle_x,
  input  wire logic signed [psf_pkg::PW-1:0] in_particle_y,
  input  wire logic signed [psf_pkg::PW-1:0] in_particle_z,
  input  wire logic signed [psf_pkg::PW-1:0] in_anchor_x,
  input  wire logic signed [psf_pkg::PW-1:0] in_anchor_y,
  input  wire logic signed [psf_pkg::PW-1:0] in_anchor_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [psf_pkg::PW-1:0]      out_force_x,
  output logic signed [psf_pkg::PW-1:0]      out_force_y,
  output logic signed [psf_pkg::PW-1:0]      out_force_z,
  output logic                               out_force_applied,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [psf_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [psf_pkg::PW-1:0]        cfg_data
);

  localparam int PW = psf_pkg::PW;

  psf_pkg::cfg_t             cfg_r;
  logic                      en;
  logic                      fr_v, sq_v, sc_v, dv_v;
  logic [psf_pkg::SQW-1:0]   fr_sum;
  psf_pkg::dvec_t            fr_dv, sq_dv;
  logic [psf_pkg::LW-1:0]    sq_len;
  psf_pkg::div_in_t          sc_d;
  logic [2:0][psf_pkg::QW-1:0] dv_q;
  psf_pkg::side_t            dv_side;
  logic                      out_valid_r;
  logic [2:0][PW-1:0]        force_r, force_nxt;
  logic                      applied_r;
  logic                      out_load;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k      <= 32'd65536;
      cfg_r.rest   <= 31'd65536;
      cfg_r.bungee <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psf_pkg::REG_SPRING: cfg_r.k      <= cfg_data;
        psf_pkg::REG_REST:   cfg_r.rest   <= cfg_data[PW-2:0];
        psf_pkg::REG_BUNGEE: cfg_r.bungee <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline moves unless a result waits in front of a held output
  assign out_load = !out_valid_r || out_ready;
  assign en       = !dv_v || out_load;
  assign in_ready = en;

  psf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_valid),
    .pos_p   ({in_particle_z, in_particle_y, in_particle_x}),
    .pos_a   ({in_anchor_z, in_anchor_y, in_anchor_x}),
    .out_v   (fr_v),
    .out_sum (fr_sum),
    .out_dv  (fr_dv)
  );

  psf_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (fr_v),
    .in_sum  (fr_sum),
    .in_dv   (fr_dv),
    .out_v   (sq_v),
    .out_len (sq_len),
    .out_dv  (sq_dv)
  );

  psf_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg    (cfg_r),
    .in_v   (sq_v),
    .in_len (sq_len),
    .in_dv  (sq_dv),
    .out_v  (sc_v),
    .out_d  (sc_d)
  );

  psf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sc_v),
    .in_d     (sc_d),
    .out_v    (dv_v),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // sign and saturation; the force points against d
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_side.kill || !dv_side.dnz[i]) begin
        force_nxt[i] = '0;
      end else if (!dv_side.dneg[i]) begin
        force_nxt[i] = dv_side.sat[i] ? {1'b1, {(PW-1){1'b0}}}
                                      : (PW'(0) - {1'b0, dv_q[i]});
      end else begin
        force_nxt[i] = dv_side.sat[i] ? {1'b0, {(PW-1){1'b1}}} : {1'b0, dv_q[i]};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && dv_v) begin
      force_r   <= force_nxt;
      applied_r <= !dv_side.kill;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_force_x       = force_r[0];
  assign out_force_y       = force_r[1];
  assign out_force_z       = force_r[2];
  assign out_force_applied = applied_r;

  // no force is reported without the applied flag
  `PSF_ASSERT_IMP(a_slack_zero, out_valid_r && !applied_r,
    force_r[0] == '0 && force_r[1] == '0 && force_r[2] == '0)
  // a finished result facing a held output stalls the input
  `PSF_ASSERT_IMP(a_stall_in, dv_v && out_valid_r && !out_ready, !in_ready)
  // that result is still there next cycle
  `PSF_ASSERT_NXT(a_keep_last, dv_v && out_valid_r && !out_ready, dv_v && out_valid_r)

endmodule
`default_nettype wire

>>> rtl/psf_front.sv
// Difference, squares and sum of squares: three register stages.
`timescale 1ns / 1ps
`default_nettype none
module psf_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_v,
  input  wire logic [2:0][psf_pkg::PW-1:0] pos_p,
  input  wire logic [2:0][psf_pkg::PW-1:0] pos_a,
  output logic                            out_v,
  output logic [psf_pkg::SQW-1:0]         out_sum,
  output psf_pkg::dvec_t                  out_dv
);

  logic [2:0]                  v_r;
  logic [2:0][psf_pkg::DW-1:0] d_r;
  logic [2:0][psf_pkg::SQW-2:0] sq_r;
  psf_pkg::dvec_t              dv2_r, dv3_r, dv2_nxt;
  logic [2:0][psf_pkg::SQW-2:0] sq_nxt;
  logic [psf_pkg::SQW-1:0]     sum_r;

  // magnitudes and squares; a magnitude of 2^32 squares to 2^64
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv2_nxt.dneg[i] = d_r[i][psf_pkg::DW-1];
      dv2_nxt.dmag[i] = d_r[i][psf_pkg::DW-1] ? (psf_pkg::DW'(0) - d_r[i]) : d_r[i];
      if (dv2_nxt.dmag[i][psf_pkg::DW-1]) begin
        sq_nxt[i] = {1'b1, {(psf_pkg::SQW-2){1'b0}}};
      end else begin
        sq_nxt[i] = {1'b0, (2*psf_pkg::PW)'(dv2_nxt.dmag[i][psf_pkg::PW-1:0])
                         * (2*psf_pkg::PW)'(dv2_nxt.dmag[i][psf_pkg::PW-1:0])};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= {pos_p[i][psf_pkg::PW-1], pos_p[i]} - {pos_a[i][psf_pkg::PW-1], pos_a[i]};
      end
      sq_r  <= sq_nxt;
      dv2_r <= dv2_nxt;
      sum_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
      dv3_r <= dv2_r;
    end
  end

  assign out_v   = v_r[2];
  assign out_sum = sum_r;
  assign out_dv  = dv3_r;

endmodule
`default_nettype wire

>>> rtl/psf_sqrt.sv
// Integer square root, one result bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module psf_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_v,
  input  wire logic [psf_pkg::SQW-1:0] in_sum,
  input  psf_pkg::dvec_t               in_dv,
  output logic                         out_v,
  output logic [psf_pkg::LW-1:0]       out_len,
  output psf_pkg::dvec_t               out_dv
);

  localparam int NS = psf_pkg::LW;

  logic                      cur_v    [NS];
  logic [psf_pkg::RMW-1:0]   cur_rem  [NS];
  logic [psf_pkg::LW-1:0]    cur_root [NS];
  logic [psf_pkg::SQW-1:0]   cur_rad  [NS];
  psf_pkg::dvec_t            cur_dv   [NS];
  logic                      v_r      [NS];
  logic [psf_pkg::RMW-1:0]   rem_r    [NS];
  logic [psf_pkg::LW-1:0]    root_r   [NS];
  logic [psf_pkg::SQW-1:0]   rad_r    [NS];
  psf_pkg::dvec_t            dv_r     [NS];

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_stage
      logic [psf_pkg::RMW-1:0] rem2, trial;
      logic                    ge;

      if (s == 0) begin : g_first
        assign cur_v[s]    = in_v;
        assign cur_rem[s]  = '0;
        assign cur_root[s] = '0;
        assign cur_rad[s]  = in_sum;
        assign cur_dv[s]   = in_dv;
      end else begin : g_rest
        assign cur_v[s]    = v_r[s-1];
        assign cur_rem[s]  = rem_r[s-1];
        assign cur_root[s] = root_r[s-1];
        assign cur_rad[s]  = rad_r[s-1];
        assign cur_dv[s]   = dv_r[s-1];
      end

      // bring down two radicand bits and try root*4+1
      assign rem2  = {cur_rem[s][psf_pkg::RMW-3:0], cur_rad[s][psf_pkg::SQW-1 -: 2]};
      assign trial = {1'b0, cur_root[s], 2'b01};
      assign ge    = rem2 >= trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= cur_v[s];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s]  <= ge ? (rem2 - trial) : rem2;
          root_r[s] <= {cur_root[s][psf_pkg::LW-2:0], ge};
          rad_r[s]  <= {cur_rad[s][psf_pkg::SQW-3:0], 2'b00};
          dv_r[s]   <= cur_dv[s];
        end
      end
    end
  endgenerate

  assign out_v   = v_r[NS-1];
  assign out_len = root_r[NS-1];
  assign out_dv  = dv_r[NS-1];

endmodule
`default_nettype wire

>>> rtl/psf_scale.sv
// Stretch, stiffness and component products, saturation test: seven stages.
`timescale 1ns / 1ps
`default_nettype none
module psf_scale (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  psf_pkg::cfg_t               cfg,
  input  wire logic                   in_v,
  input  wire logic [psf_pkg::LW-1:0] in_len,
  input  psf_pkg::dvec_t              in_dv,
  output logic                        out_v,
  output psf_pkg::div_in_t            out_d
);

  localparam int PW = psf_pkg::PW;

  logic [6:0]                 v_r;
  logic [psf_pkg::LW-1:0]     len_r [7];
  psf_pkg::dvec_t             dv_r  [4];
  logic                       kill_r [7];
  logic [2:0]                 dnz_r [7];
  logic [psf_pkg::LW-1:0]     stretch_r;
  logic [2*PW-1:0]            pk_r;
  logic                       shi_r;
  logic [psf_pkg::SCW-1:0]    scale_r, scale4_r;
  logic [2:0][2*PW-1:0]       p0_r, p1_r;
  logic [2:0][psf_pkg::NW-1:0] a_r, b_r;
  logic [2:0][psf_pkg::NSW-1:0] ns_r, ns7_r;
  logic [2:0]                 sat_r;
  logic [2:0]                 dneg5_r, dneg6_r, dneg7_r;
  logic [psf_pkg::LW-1:0]     rest_ext;
  logic                       kill_nxt;
  logic [2:0]                 dnz_nxt;

  assign rest_ext = {2'b00, cfg.rest};

  // length zero, or slack in bungee mode, gives no force
  always_comb begin
    kill_nxt = (in_len == '0) || (cfg.bungee && (in_len <= rest_ext));
    for (int i = 0; i < 3; i++) begin
      dnz_nxt[i] = in_dv.dmag[i] != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: stretch
      stretch_r <= (in_len >= rest_ext) ? (in_len - rest_ext) : (rest_ext - in_len);
      len_r[0]  <= in_len;
      dv_r[0]   <= in_dv;
      kill_r[0] <= kill_nxt;
      dnz_r[0]  <= dnz_nxt;
      for (int s = 1; s < 7; s++) begin
        len_r[s]  <= len_r[s-1];
        kill_r[s] <= kill_r[s-1];
        dnz_r[s]  <= dnz_r[s-1];
      end
      for (int s = 1; s < 4; s++) begin
        dv_r[s] <= dv_r[s-1];
      end
      // stage 2: low part of stretch times k
      pk_r  <= stretch_r[PW-1:0] * cfg.k;
      shi_r <= stretch_r[psf_pkg::LW-1];
      // stage 3: add the top stretch bit's share
      scale_r <= {1'b0, pk_r} + (shi_r ? {1'b0, cfg.k, {PW{1'b0}}} : '0);
      // stage 4: partial products per component
      for (int i = 0; i < 3; i++) begin
        p0_r[i] <= scale_r[PW-1:0] * dv_r[2].dmag[i][PW-1:0];
        p1_r[i] <= scale_r[2*PW-1:PW] * dv_r[2].dmag[i][PW-1:0];
      end
      scale4_r <= scale_r;
      // stage 5: line the partial products up; a top magnitude bit means low part zero
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= {{(psf_pkg::NW-2*PW){1'b0}}, p0_r[i]}
                + {2'b00, p1_r[i], {PW{1'b0}}};
        b_r[i] <= (dv_r[3].dmag[i][PW] ? {1'b0, scale4_r, {PW{1'b0}}} : '0)
                | (scale4_r[psf_pkg::SCW-1] ? {2'b00, dv_r[3].dmag[i][PW-1:0], {(2*PW){1'b0}}}
                                             : '0);
      end
      dneg5_r <= dv_r[3].dneg;
      // stage 6: full numerator, fraction bits dropped
      for (int i = 0; i < 3; i++) begin
        ns_r[i] <= psf_pkg::NSW'((a_r[i] + b_r[i]) >> psf_pkg::FRAC_BITS);
      end
      dneg6_r <= dneg5_r;
      // stage 7: quotient of 2^31 or more saturates
      for (int i = 0; i < 3; i++) begin
        sat_r[i] <= ns_r[i] >= psf_pkg::NSW'({len_r[5], {psf_pkg::QW{1'b0}}});
      end
      ns7_r   <= ns_r;
      dneg7_r <= dneg6_r;
    end
  end

  assign out_v               = v_r[6];
  assign out_d.side.kill     = kill_r[6];
  assign out_d.side.sat      = sat_r;
  assign out_d.side.dneg     = dneg7_r;
  assign out_d.side.dnz      = dnz_r[6];
  assign out_d.len           = len_r[6];
  assign out_d.num           = ns7_r;

endmodule
`default_nettype wire

>>> rtl/psf_div.sv
// Restoring divider for three components, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module psf_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_v,
  input  psf_pkg::div_in_t                in_d,
  output logic                            out_v,
  output logic [2:0][psf_pkg::QW-1:0]     out_q,
  output psf_pkg::side_t                  out_side
);

  localparam int NS = psf_pkg::QW;
  localparam int LW = psf_pkg::LW;

  logic                       cur_v   [NS];
  logic [LW-1:0]              cur_len [NS];
  psf_pkg::side_t             cur_sd  [NS];
  logic [2:0][LW-1:0]         cur_rem [NS];
  logic [2:0][NS-1:0]         cur_nb  [NS];
  logic                       v_r     [NS];
  logic [LW-1:0]              len_r   [NS];
  psf_pkg::side_t             sd_r    [NS];
  logic [2:0][LW-1:0]         rem_r   [NS];
  logic [2:0][NS-1:0]         nb_r    [NS];

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_stage
      logic [2:0][LW-1:0] rem_nxt;
      logic [2:0][NS-1:0] nb_nxt;

      if (s == 0) begin : g_first
        assign cur_v[s]   = in_v;
        assign cur_len[s] = in_d.len;
        assign cur_sd[s]  = in_d.side;
        for (genvar i = 0; i < 3; i++) begin : g_ln
          // upper dividend bits are below the divisor when not saturated
          assign cur_rem[s][i] = in_d.num[i][NS+LW-1:NS];
          assign cur_nb[s][i]  = in_d.num[i][NS-1:0];
        end
      end else begin : g_rest
        assign cur_v[s]   = v_r[s-1];
        assign cur_len[s] = len_r[s-1];
        assign cur_sd[s]  = sd_r[s-1];
        assign cur_rem[s] = rem_r[s-1];
        assign cur_nb[s]  = nb_r[s-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
        logic [LW:0] t;
        logic        ge;
        for (int i = 0; i < 3; i++) begin
          t  = {cur_rem[s][i], cur_nb[s][i][NS-1]};
          ge = t >= {1'b0, cur_len[s]};
          rem_nxt[i] = ge ? LW'(t - {1'b0, cur_len[s]}) : t[LW-1:0];
          nb_nxt[i]  = {cur_nb[s][i][NS-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= cur_v[s];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          len_r[s] <= cur_len[s];
          sd_r[s]  <= cur_sd[s];
          rem_r[s] <= rem_nxt;
          nb_r[s]  <= nb_nxt;
        end
      end
    end
  endgenerate

  assign out_v    = v_r[NS-1];
  assign out_q    = nb_r[NS-1];
  assign out_side = sd_r[NS-1];

endmodule
`default_nettype wire

>>> tb/sv/spring_force_checker.sv
// Checker for the spring force block: predicts each force request and compares it.
`timescale 1ns / 1ps
`default_nettype none
module spring_force_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic signed [psf_pkg::PW-1:0] in_particle_x,
  input  wire logic signed [psf_pkg::PW-1:0] in_particle_y,
  input  wire logic signed [psf_pkg::PW-1:0] in_particle_z,
  input  wire logic signed [psf_pkg::PW-1:0] in_anchor_x,
  input  wire logic signed [psf_pkg::PW-1:0] in_anchor_y,
  input  wire logic signed [psf_pkg::PW-1:0] in_anchor_z,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic signed [psf_pkg::PW-1:0] out_force_x,
  input  wire logic signed [psf_pkg::PW-1:0] out_force_y,
  input  wire logic signed [psf_pkg::PW-1:0] out_force_z,
  input  wire logic                          out_force_applied,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [psf_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [psf_pkg::PW-1:0]        cfg_data,
  output int                                 fail_count,
  output int                                 pending_forces,
  output int                                 forces_seen
);
  import psf_pkg::*;

  typedef struct packed {
    logic signed [PW-1:0] fx;
    logic signed [PW-1:0] fy;
    logic signed [PW-1:0] fz;
    logic                 applied;
  } force_t;

  force_t     force_q[$];
  logic [31:0] k_reg;
  logic [30:0] rest_reg;
  logic        bungee_reg;

  // floor of the square root of a sum of squares
  function automatic logic [63:0] root_floor(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] c2;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      c2 = 128'(c) * 128'(c);
      if (c2 <= s) r = c;
    end
    return r;
  endfunction

  function automatic force_t predict_force(logic signed [PW-1:0] p[3],
                                           logic signed [PW-1:0] a[3]);
    force_t        f;
    logic signed [33:0] d[3];
    logic [33:0]   m[3];
    logic [127:0]  sum;
    logic [63:0]   len, stretch;
    logic [127:0]  q, den;
    logic [31:0]   comp[3];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 34'(p[i]) - 34'(a[i]);
      m[i] = d[i] < 0 ? 34'(-d[i]) : 34'(d[i]);
      sum += 128'(m[i]) * 128'(m[i]);
    end
    len = root_floor(sum);
    f = '0;
    // zero length or slack bungee gives no force
    if (len == 0 || (bungee_reg && len <= 64'(rest_reg))) return f;
    stretch = len >= 64'(rest_reg) ? len - 64'(rest_reg) : 64'(rest_reg) - len;
    den = 128'(len) << FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      q = (128'(stretch) * 128'(k_reg) * 128'(m[i])) / den;
      if (d[i] > 0)
        comp[i] = (q >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
      else if (d[i] < 0)
        comp[i] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      else
        comp[i] = '0;
    end
    f.fx = comp[0];
    f.fy = comp[1];
    f.fz = comp[2];
    f.applied = 1'b1;
    return f;
  endfunction

  always @(posedge clk) begin
    logic signed [PW-1:0] p[3];
    logic signed [PW-1:0] a[3];
    force_t exp_f;
    if (!rst_n) begin
      k_reg = 32'd65536;
      rest_reg = 31'd65536;
      bungee_reg = 1'b0;
      force_q.delete();
      fail_count = 0;
      forces_seen = 0;
    end else begin
      // compare an outgoing request with the oldest prediction
      if (out_valid && out_ready) begin
        forces_seen++;
        if (force_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected force request %h %h %h %b", $time,
                   out_force_x, out_force_y, out_force_z, out_force_applied);
        end else begin
          exp_f = force_q.pop_front();
          if (exp_f.fx !== out_force_x || exp_f.fy !== out_force_y ||
              exp_f.fz !== out_force_z || exp_f.applied !== out_force_applied) begin
            fail_count++;
            $display("%0t: force mismatch expected %h %h %h %b actual %h %h %h %b",
                     $time, exp_f.fx, exp_f.fy, exp_f.fz, exp_f.applied,
                     out_force_x, out_force_y, out_force_z, out_force_applied);
          end
        end
      end
      // predict each accepted position request
      if (in_valid && in_ready) begin
        p[0] = in_particle_x; p[1] = in_particle_y; p[2] = in_particle_z;
        a[0] = in_anchor_x;   a[1] = in_anchor_y;   a[2] = in_anchor_z;
        force_q.push_back(predict_force(p, a));
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPRING: k_reg = cfg_data;
          REG_REST:   rest_reg = cfg_data[30:0];
          REG_BUNGEE: bungee_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending_forces = force_q.size();
  end
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Top of the spring force testbench: stimulus, register phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import psf_pkg::*;

  localparam int LATENCY = 75;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [PW-1:0] in_particle_x = '0, in_particle_y = '0, in_particle_z = '0;
  logic signed [PW-1:0] in_anchor_x = '0, in_anchor_y = '0, in_anchor_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PW-1:0] out_force_x, out_force_y, out_force_z;
  logic out_force_applied;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [PW-1:0] cfg_data = '0;
  int fail_count, pending_forces, forces_seen;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  always #6 clk = ~clk;

  particle_spring_force dut (.*);

  spring_force_checker u_chk (.*);

  // short gaps mostly, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic send_pos(logic [31:0] px, py, pz, ax, ay, az);
    in_valid <= 1'b1;
    in_particle_x <= px; in_particle_y <= py; in_particle_z <= pz;
    in_anchor_x <= ax;   in_anchor_y <= ay;   in_anchor_z <= az;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap_len() != 0 || stim_done) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_random(int count);
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0)
        send_pos(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                 rand_coord(mode), rand_coord(mode), rand_coord(mode));
      else begin
        // anchor near the particle so lengths straddle the rest length
        logic [31:0] px, py, pz;
        px = rand_coord(mode); py = rand_coord(mode); pz = rand_coord(mode);
        send_pos(px, py, pz, px + rand_coord(1 + (mode & 1) * 2),
                 py + rand_coord(1), pz - rand_coord(3));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver side: random stalls, plus one long hold when asked
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      g = gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero length, exact rest and axes
    send_pos(0, 0, 0, 0, 0, 0);
    send_pos(32'h0001_0000, 0, 0, 0, 0, 0);
    send_pos(0, 32'hFFFF_0000, 0, 0, 0, 0);
    send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pos(32'h0000_0001, 0, 0, 0, 0, 0);
    send_pos(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
    send_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    send_pos(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
             32'hF0F0_F0F0, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();

    write_reg(REG_SPRING, 32'hFFFF_FFFF);
    write_reg(REG_REST, 32'h0000_0000);
    write_reg(REG_BUNGEE, 32'h1);
    write_reg(2'd3, 32'hDEAD_BEEF);
    send_pos(32'h7FFF_FFFF, 0, 32'h0000_0001, 32'h8000_0000, 0, 0);
    send_pos(32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_random(150);
    drain();

    write_reg(REG_SPRING, 32'h0000_0000);
    write_reg(REG_REST, 32'h7FFF_FFFF);
    send_pos(32'h0002_0000, 0, 0, 0, 0, 0);
    send_random(60);
    drain();

    // bungee slack against a large rest length, then pressure phase
    write_reg(REG_SPRING, 32'h0002_8000);
    write_reg(REG_REST, 32'h0004_0000);
    write_reg(REG_BUNGEE, 32'h1);
    send_pos(32'h0002_0000, 0, 0, 0, 0, 0);
    send_pos(32'h0004_0000, 0, 0, 0, 0, 0);
    send_pos(32'h0008_0000, 0, 0, 0, 0, 0);
    long_hold = 1'b1;
    send_random(250);
    drain();

    // reset values again, then broad random settings
    write_reg(REG_SPRING, 32'd65536);
    write_reg(REG_REST, 32'd65536);
    write_reg(REG_BUNGEE, 32'h0);
    send_random(250);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_SPRING, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20));
      write_reg(REG_REST, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 19));
      write_reg(REG_BUNGEE, $urandom());
      send_random(95);
      drain();
    end
    stim_done = 1'b1;

    $display("Covered register extremes, bungee slack, zero length and saturation");
    $display("over %0d force requests with random stalls on both sides.", forces_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
